// ===== hw/rtl/eta_pkg.sv =====
`default_nettype none

package eta_pkg;

   localparam int VALUE_BITS = 16;
   localparam int TIME_BITS = 16;
   localparam int SINE_TABLE_DEPTH = 256;

   localparam int FRAC_BITS = 15;
   localparam int Q_BITS = FRAC_BITS + 2;
   localparam int SINE_IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int CSR_DATA_W = (VALUE_BITS > TIME_BITS) ? VALUE_BITS : TIME_BITS;
   localparam int CSR_INDEX_W = 3;
   localparam int LOOP_BITS = 8;
   localparam int MODE_BITS = 4;
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int DIV_CNT_W = $clog2(FRAC_BITS);

   localparam logic [Q_BITS-1:0] ONE_Q = Q_BITS'(1) << FRAC_BITS;
   localparam logic [Q_BITS-1:0] HALF_Q = Q_BITS'(1) << (FRAC_BITS - 1);

   localparam longint unsigned HALFPI_Q30 = 64'd1686629713;

   localparam logic [CSR_INDEX_W-1:0] CSR_DURATION = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELAY = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOP_COUNT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_EASING = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_START = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_END = 3'd5;

   localparam logic [MODE_BITS-1:0] EASE_LINEAR = 4'd0;
   localparam logic [MODE_BITS-1:0] EASE_QUAD_IN = 4'd1;
   localparam logic [MODE_BITS-1:0] EASE_QUAD_OUT = 4'd2;
   localparam logic [MODE_BITS-1:0] EASE_QUAD_INOUT = 4'd3;
   localparam logic [MODE_BITS-1:0] EASE_CUBIC_IN = 4'd4;
   localparam logic [MODE_BITS-1:0] EASE_CUBIC_OUT = 4'd5;
   localparam logic [MODE_BITS-1:0] EASE_CUBIC_INOUT = 4'd6;
   localparam logic [MODE_BITS-1:0] EASE_SINE_IN = 4'd7;
   localparam logic [MODE_BITS-1:0] EASE_SINE_OUT = 4'd8;
   localparam logic [MODE_BITS-1:0] EASE_SINE_INOUT = 4'd9;

   localparam logic [2:0] CMD_TICK = 3'd0;
   localparam logic [2:0] CMD_PLAY = 3'd1;
   localparam logic [2:0] CMD_PAUSE = 3'd2;
   localparam logic [2:0] CMD_STOP = 3'd3;
   localparam logic [2:0] CMD_SEEK = 3'd4;

   typedef enum logic [1:0] {
      RS_STOPPED,
      RS_PLAYING,
      RS_PAUSED,
      RS_FINISHED
   } run_state_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_SQR,
      ST_EASE2,
      ST_CUBE_FIN,
      ST_SINE_RD,
      ST_SINE_MUL,
      ST_SINE_FIN,
      ST_LERP_MUL,
      ST_LERP_FIN,
      ST_OUT
   } seq_state_type;

   typedef logic [FRAC_BITS:0] sine_rom_type [0:SINE_TABLE_DEPTH];

   // Shift-and-subtract division, only used while the table is built.
   function automatic longint unsigned div_u64(input longint unsigned num,
                                               input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = 0;
      rem = 0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Integer Taylor series of sin(x), x in Q2.30, evaluated at elaboration.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      longint unsigned x;
      longint unsigned term;
      longint sum;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x = HALFPI_Q30 * longint'(k) / SINE_TABLE_DEPTH;
         term = x;
         sum = longint'(x);
         for (int n = 1; n <= 8; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = div_u64(term, 64'((2 * n) * (2 * n + 1)));
            if (n % 2 == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         rom[k] = (FRAC_BITS + 1)'((sum + 16384) >>> 15);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

// ===== hw/rtl/eased_tween_animator.sv =====
`default_nettype none

// Command-driven tween animator. Each req item carries a command; play, pause,
// stop, seek and ticks that do not animate are absorbed in the idle state with
// no rsp item. A tick that animates produces one rsp item with the interpolated
// value, the eased Q1.15 progress and a finished flag. Such a tick runs through
// a restoring divider that forms elapsed/duration, then one shared 33x18
// multiplier is reused for the easing curve (up to two passes) and the final
// interpolation. A tick that ends a loop skips the divider and the easing.
// The block returns to idle only after the rsp item is accepted, and only then
// takes the next req item. req_stall is high while an item is in work or its
// result waits on rsp_stall. The csr port is always ready and should be written
// only while the block is idle.
module eased_tween_animator
   import eta_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [2:0]                    req_cmd,
   input  wire logic [TIME_BITS-1:0]          req_delta,
   input  wire logic [TIME_BITS-1:0]          req_seek_position,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [VALUE_BITS-1:0]       rsp_value,
   output logic [FRAC_BITS:0]                 rsp_progress,
   output logic                               rsp_finished,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]        csr_index,
   input  wire logic [CSR_DATA_W-1:0]         csr_wdata
);

   localparam logic [TIME_BITS:0] ELAPSED_MAX = '1;

   seq_state_type state_ff, state_in;
   run_state_type run_ff, run_in;
   logic [TIME_BITS:0] elapsed_ff, elapsed_in;
   logic [TIME_BITS-1:0] delay_left_ff, delay_left_in;
   logic [LOOP_BITS-1:0] loops_left_ff, loops_left_in;

   logic [TIME_BITS-1:0] duration_ff, delay_ticks_ff;
   logic [LOOP_BITS-1:0] loop_count_ff;
   logic [MODE_BITS-1:0] mode_ff;
   logic signed [VALUE_BITS-1:0] start_ff, end_ff;

   logic [TIME_BITS-1:0] rem_ff, rem_in;
   logic [FRAC_BITS-1:0] q_ff, q_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [Q_BITS-1:0] a_ff, a_in;
   logic signed [MUL_P_W-1:0] prod_ff;
   logic [FRAC_BITS:0] lo_ff, lo_in;
   logic [Q_BITS-1:0] dif_ff, dif_in;
   logic [FRAC_BITS-1:0] frac_ff, frac_in;
   logic [Q_BITS-1:0] p_ff, p_in;
   logic fin_ff, fin_in;
   logic signed [VALUE_BITS-1:0] value_ff, value_in;
   logic [FRAC_BITS:0] progress_ff;

   logic req_acc;
   logic tick_anim, tick_end;
   logic [TIME_BITS:0] el_new;
   logic [TIME_BITS-1:0] dly_new;
   logic [LOOP_BITS-1:0] loops_new;
   logic end_fin;
   logic [TIME_BITS:0] dur;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;

   logic is_quad, is_cubic, is_sine, u_low;
   logic [Q_BITS-1:0] u17;

   function automatic logic [Q_BITS-1:0] clamp_q(input logic [47:0] r);
      if (r > 48'(ONE_Q)) begin
         return ONE_Q;
      end
      return r[Q_BITS-1:0];
   endfunction

   assign req_acc = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign csr_ready = 1'b1;
   assign rsp_value = value_ff;
   assign rsp_progress = progress_ff;
   assign rsp_finished = fin_ff;

   assign dur = (duration_ff == '0) ? (TIME_BITS + 1)'(1) : {1'b0, duration_ff};
   assign u17 = {2'b00, q_ff};
   assign u_low = (u17 < HALF_Q);
   assign is_quad = (mode_ff >= EASE_QUAD_IN) && (mode_ff <= EASE_QUAD_INOUT);
   assign is_cubic = (mode_ff >= EASE_CUBIC_IN) && (mode_ff <= EASE_CUBIC_INOUT);
   assign is_sine = (mode_ff >= EASE_SINE_IN) && (mode_ff <= EASE_SINE_INOUT);

   // Tick evaluation: delay, elapsed advance and loop bookkeeping.
   always_comb begin
      logic [TIME_BITS-1:0] d;
      logic [TIME_BITS+1:0] sum;
      d = req_delta;
      dly_new = delay_left_ff;
      tick_anim = (req_cmd == CMD_TICK) && (run_ff == RS_PLAYING);
      if (delay_left_ff != '0) begin
         if (req_delta < delay_left_ff) begin
            dly_new = delay_left_ff - req_delta;
            tick_anim = 1'b0;
         end else begin
            d = req_delta - delay_left_ff;
            dly_new = '0;
         end
      end
      sum = (TIME_BITS + 2)'(elapsed_ff) + (TIME_BITS + 2)'(d);
      el_new = (sum > (TIME_BITS + 2)'(ELAPSED_MAX)) ? ELAPSED_MAX : sum[TIME_BITS:0];
      tick_end = (el_new >= dur);
      loops_new = loops_left_ff;
      end_fin = 1'b1;
      if (loops_left_ff != '0) begin
         if (!loops_left_ff[LOOP_BITS-1]) begin
            loops_new = loops_left_ff - 1'b1;
         end
         end_fin = (loops_new == '0);
      end
   end

   // Shared multiplier operand selection.
   always_comb begin
      logic [Q_BITS-1:0] w;
      logic [Q_BITS-1:0] x;
      mul_a = '0;
      mul_b = '0;
      w = '0;
      x = '0;
      case (state_ff)
         ST_SQR: begin
            if (is_sine) begin
               if (mode_ff == EASE_SINE_IN) begin
                  x = ONE_Q - u17;
               end else if (mode_ff == EASE_SINE_OUT) begin
                  x = u17;
               end else if (u_low) begin
                  x = ONE_Q - (u17 << 1);
               end else begin
                  x = (u17 << 1) - ONE_Q;
               end
               mul_a = MUL_A_W'(x);
               mul_b = MUL_B_W'(SINE_TABLE_DEPTH);
            end else if (mode_ff == EASE_QUAD_OUT) begin
               mul_a = MUL_A_W'(u17);
               mul_b = MUL_B_W'((ONE_Q << 1) - (Q_BITS + 1)'(u17));
            end else begin
               if (mode_ff == EASE_CUBIC_OUT) begin
                  w = ONE_Q - u17;
               end else if ((mode_ff == EASE_QUAD_INOUT || mode_ff == EASE_CUBIC_INOUT)
                            && !u_low) begin
                  w = (ONE_Q - u17) << 1;
               end else begin
                  w = u17;
               end
               mul_a = MUL_A_W'(w);
               mul_b = MUL_B_W'(w);
            end
         end
         ST_EASE2: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = MUL_B_W'(a_ff);
         end
         ST_SINE_MUL: begin
            mul_a = MUL_A_W'(dif_ff);
            mul_b = MUL_B_W'(frac_ff);
         end
         ST_LERP_MUL: begin
            mul_a = MUL_A_W'($signed({end_ff[VALUE_BITS-1], end_ff})
                             - $signed({start_ff[VALUE_BITS-1], start_ff}));
            mul_b = $signed({1'b0, p_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && tick_anim) begin
               state_in = tick_end ? ST_LERP_MUL : ST_DIV;
            end
         end
         ST_DIV: begin
            if (cnt_ff == DIV_CNT_W'(FRAC_BITS - 1)) begin
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            if (is_sine) begin
               state_in = ST_SINE_RD;
            end else if (is_quad || is_cubic) begin
               state_in = ST_EASE2;
            end else begin
               state_in = ST_LERP_MUL;
            end
         end
         ST_EASE2:    state_in = is_cubic ? ST_CUBE_FIN : ST_LERP_MUL;
         ST_CUBE_FIN: state_in = ST_LERP_MUL;
         ST_SINE_RD:  state_in = ST_SINE_MUL;
         ST_SINE_MUL: state_in = ST_SINE_FIN;
         ST_SINE_FIN: state_in = ST_LERP_MUL;
         ST_LERP_MUL: state_in = ST_LERP_FIN;
         ST_LERP_FIN: state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and run-state updates.
   always_comb begin
      logic [TIME_BITS:0] t2;
      logic [47:0] pu;
      logic [47:0] r;
      logic [SINE_IDX_W-1:0] idx;
      logic [FRAC_BITS:0] hi;
      logic [FRAC_BITS:0] lo;
      logic [Q_BITS-1:0] s;
      logic signed [MUL_P_W-1:0] num;
      logic signed [MUL_P_W-1:0] v;
      run_in = run_ff;
      elapsed_in = elapsed_ff;
      delay_left_in = delay_left_ff;
      loops_left_in = loops_left_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      a_in = a_ff;
      lo_in = lo_ff;
      dif_in = dif_ff;
      frac_in = frac_ff;
      p_in = p_ff;
      fin_in = fin_ff;
      value_in = value_ff;
      t2 = '0;
      pu = prod_ff[47:0];
      r = '0;
      idx = '0;
      hi = '0;
      lo = '0;
      s = '0;
      num = '0;
      v = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_cmd)
                  CMD_TICK: begin
                     if (run_ff == RS_PLAYING) begin
                        delay_left_in = dly_new;
                        if (tick_anim) begin
                           fin_in = 1'b0;
                           elapsed_in = el_new;
                           rem_in = el_new[TIME_BITS-1:0];
                           q_in = '0;
                           cnt_in = '0;
                           if (tick_end) begin
                              p_in = ONE_Q;
                              loops_left_in = loops_new;
                              fin_in = end_fin;
                              if (end_fin) begin
                                 run_in = RS_FINISHED;
                              end
                              if (loops_left_ff != '0) begin
                                 elapsed_in = '0;
                              end
                           end
                        end
                     end
                  end
                  CMD_PLAY: begin
                     if (run_ff != RS_PLAYING) begin
                        run_in = RS_PLAYING;
                        elapsed_in = '0;
                        delay_left_in = delay_ticks_ff;
                        loops_left_in = loop_count_ff;
                     end
                  end
                  CMD_PAUSE: begin
                     if (run_ff == RS_PLAYING) begin
                        run_in = RS_PAUSED;
                     end
                  end
                  CMD_STOP: begin
                     run_in = RS_STOPPED;
                     elapsed_in = '0;
                     delay_left_in = '0;
                  end
                  CMD_SEEK: begin
                     elapsed_in = {1'b0, req_seek_position};
                  end
                  default: begin
                     run_in = run_ff;
                  end
               endcase
            end
         end
         ST_DIV: begin
            // The remainder stays below the duration, so it fits TIME_BITS.
            t2 = {rem_ff, 1'b0};
            if (t2 >= dur) begin
               t2 = t2 - dur;
               q_in = {q_ff[FRAC_BITS-2:0], 1'b1};
            end else begin
               q_in = {q_ff[FRAC_BITS-2:0], 1'b0};
            end
            rem_in = t2[TIME_BITS-1:0];
            cnt_in = cnt_ff + 1'b1;
         end
         ST_SQR: begin
            a_in = mul_b[Q_BITS-1:0];
            p_in = u17;
         end
         ST_EASE2: begin
            if (mode_ff == EASE_QUAD_INOUT) begin
               if (u_low) begin
                  r = ((pu << 1) + 48'(HALF_Q)) >> 15;
               end else begin
                  r = 48'(ONE_Q) - ((pu + 48'(ONE_Q)) >> 16);
               end
            end else begin
               r = (pu + 48'(HALF_Q)) >> 15;
            end
            p_in = clamp_q(r);
         end
         ST_CUBE_FIN: begin
            if (mode_ff == EASE_CUBIC_IN) begin
               r = (pu + (48'd1 << 29)) >> 30;
            end else if (mode_ff == EASE_CUBIC_OUT) begin
               r = 48'(ONE_Q) - ((pu + (48'd1 << 29)) >> 30);
            end else if (u_low) begin
               r = ((pu << 2) + (48'd1 << 29)) >> 30;
            end else begin
               r = 48'(ONE_Q) - ((pu + (48'd1 << 30)) >> 31);
            end
            p_in = clamp_q(r);
         end
         ST_SINE_RD: begin
            idx = pu[FRAC_BITS+SINE_IDX_W-1:FRAC_BITS];
            frac_in = pu[FRAC_BITS-1:0];
            if (idx >= SINE_IDX_W'(SINE_TABLE_DEPTH)) begin
               lo_in = SINE_ROM[SINE_TABLE_DEPTH];
               dif_in = '0;
            end else begin
               lo = SINE_ROM[idx];
               hi = SINE_ROM[idx + 1'b1];
               lo_in = lo;
               dif_in = (hi < lo) ? '0 : Q_BITS'(hi - lo);
            end
         end
         ST_SINE_FIN: begin
            s = Q_BITS'(lo_ff) + Q_BITS'((pu + 48'(HALF_Q)) >> 15);
            if (mode_ff == EASE_SINE_IN) begin
               r = 48'(ONE_Q) - 48'(s);
            end else if (mode_ff == EASE_SINE_OUT) begin
               r = 48'(s);
            end else if (u_low) begin
               r = (48'(ONE_Q) - 48'(s) + 48'd1) >> 1;
            end else begin
               r = (48'(ONE_Q) + 48'(s) + 48'd1) >> 1;
            end
            p_in = clamp_q(r);
         end
         ST_LERP_FIN: begin
            // An arithmetic shift gives the floor, which matches the
            // round-half-up rule for negative products too.
            num = prod_ff + MUL_P_W'(HALF_Q);
            v = (num >>> FRAC_BITS) + MUL_P_W'(start_ff);
            if (v > MUL_P_W'((1 <<< (VALUE_BITS - 1)) - 1)) begin
               value_in = {1'b0, {(VALUE_BITS - 1){1'b1}}};
            end else if (v < -(MUL_P_W'(1) <<< (VALUE_BITS - 1))) begin
               value_in = {1'b1, {(VALUE_BITS - 1){1'b0}}};
            end else begin
               value_in = v[VALUE_BITS-1:0];
            end
         end
         default: begin
            p_in = p_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         run_ff <= RS_STOPPED;
         elapsed_ff <= '0;
         delay_left_ff <= '0;
         loops_left_ff <= '0;
         duration_ff <= TIME_BITS'(1000);
         delay_ticks_ff <= '0;
         loop_count_ff <= '0;
         mode_ff <= EASE_LINEAR;
         start_ff <= '0;
         end_ff <= '0;
      end else begin
         state_ff <= state_in;
         run_ff <= run_in;
         elapsed_ff <= elapsed_in;
         delay_left_ff <= delay_left_in;
         loops_left_ff <= loops_left_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DURATION:   duration_ff <= csr_wdata[TIME_BITS-1:0];
               CSR_DELAY:      delay_ticks_ff <= csr_wdata[TIME_BITS-1:0];
               CSR_LOOP_COUNT: loop_count_ff <= csr_wdata[LOOP_BITS-1:0];
               CSR_EASING:     mode_ff <= csr_wdata[MODE_BITS-1:0];
               CSR_START:      start_ff <= csr_wdata[VALUE_BITS-1:0];
               CSR_END:        end_ff <= csr_wdata[VALUE_BITS-1:0];
               default: begin
                  mode_ff <= mode_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff <= q_in;
      cnt_ff <= cnt_in;
      a_ff <= a_in;
      prod_ff <= mul_p;
      lo_ff <= lo_in;
      dif_ff <= dif_in;
      frac_ff <= frac_in;
      p_ff <= p_in;
      fin_ff <= fin_in;
      value_ff <= value_in;
      if (state_ff == ST_LERP_FIN) begin
         progress_ff <= p_ff[FRAC_BITS:0];
      end
   end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
module tb;
   import eta_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic [FRAC_BITS:0]           progress;
      logic                         finished;
   } frame_type;

   // Command and easing codes that the block does not define.
   localparam logic [2:0] CMD_RSVD_LO = 3'd5;
   localparam logic [2:0] CMD_RSVD_HI = 3'd7;
   localparam logic [3:0] EASE_RSVD_TOP = 4'd15;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_cmd = CMD_TICK;
   logic [TIME_BITS-1:0] req_delta = '0;
   logic [TIME_BITS-1:0] req_seek_position = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [VALUE_BITS-1:0] rsp_value;
   logic [FRAC_BITS:0] rsp_progress;
   logic rsp_finished;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_DURATION;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   eased_tween_animator i_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Animator model state and register copies.
   logic [15:0] dur_reg, delay_reg, start_reg, end_reg;
   logic [7:0]  loops_reg;
   logic [3:0]  mode_reg;
   run_state_type play_state;
   longint unsigned elapsed_t, delay_left_t;
   int unsigned loops_left_t;
   longint unsigned sine_tab [0:SINE_TABLE_DEPTH];

   frame_type frames_due[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   function automatic void make_sine_tab();
      longint unsigned x, term;
      longint sum;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x = 64'd1686629713 * longint'(k) / SINE_TABLE_DEPTH;
         term = x;
         sum = longint'(x);
         for (int n = 1; n <= 8; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         sine_tab[k] = (unsigned'(sum) + 16384) >> 15;
      end
   endfunction

   function automatic longint unsigned quarter_sine(longint unsigned x);
      longint unsigned pos, frac, lo, hi, i;
      if (x > 32768) x = 32768;
      pos = x * SINE_TABLE_DEPTH;
      i = pos >> 15;
      frac = pos & 32767;
      if (i >= SINE_TABLE_DEPTH) return sine_tab[SINE_TABLE_DEPTH];
      lo = sine_tab[i];
      hi = sine_tab[i + 1];
      if (hi < lo) hi = lo;
      return lo + (((hi - lo) * frac + 16384) >> 15);
   endfunction

   function automatic longint unsigned eased(longint unsigned u, logic [3:0] mode);
      longint unsigned w, r;
      case (mode)
         EASE_QUAD_IN: r = (u * u + 16384) >> 15;
         EASE_QUAD_OUT: r = (u * (65536 - u) + 16384) >> 15;
         EASE_QUAD_INOUT: begin
            if (u < 16384) r = (2 * u * u + 16384) >> 15;
            else begin
               w = 2 * (32768 - u);
               r = 32768 - ((w * w + 32768) >> 16);
            end
         end
         EASE_CUBIC_IN: r = (u * u * u + (64'd1 << 29)) >> 30;
         EASE_CUBIC_OUT: begin
            w = 32768 - u;
            r = 32768 - ((w * w * w + (64'd1 << 29)) >> 30);
         end
         EASE_CUBIC_INOUT: begin
            if (u < 16384) r = (4 * u * u * u + (64'd1 << 29)) >> 30;
            else begin
               w = 2 * (32768 - u);
               r = 32768 - ((w * w * w + (64'd1 << 30)) >> 31);
            end
         end
         EASE_SINE_IN: r = 32768 - quarter_sine(32768 - u);
         EASE_SINE_OUT: r = quarter_sine(u);
         EASE_SINE_INOUT: begin
            if (u < 16384) r = (32768 - quarter_sine(32768 - 2 * u) + 1) >> 1;
            else r = (32768 + quarter_sine(2 * u - 32768) + 1) >> 1;
         end
         default: r = u;
      endcase
      if (r > 32768) r = 32768;
      return r;
   endfunction

   function automatic logic [15:0] blend(longint unsigned p);
      longint s, e, num, q, v;
      s = longint'(signed'(start_reg));
      e = longint'(signed'(end_reg));
      num = (e - s) * longint'(p) + 16384;
      if (num >= 0) q = num >>> 15;
      else q = -((-num + 32767) >>> 15);
      v = s + q;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   // Advances the animator state for one command; pushes a frame if one is due.
   function automatic void animate(logic [2:0] cmd, logic [15:0] delta, logic [15:0] seek);
      longint unsigned d, dur, p;
      logic fin;
      frame_type f;
      d = delta;
      fin = 1'b0;
      case (cmd)
         CMD_PLAY: begin
            if (play_state != RS_PLAYING) begin
               play_state = RS_PLAYING;
               elapsed_t = 0;
               delay_left_t = delay_reg;
               loops_left_t = loops_reg;
            end
            return;
         end
         CMD_PAUSE: begin
            if (play_state == RS_PLAYING) play_state = RS_PAUSED;
            return;
         end
         CMD_STOP: begin
            play_state = RS_STOPPED;
            elapsed_t = 0;
            delay_left_t = 0;
            return;
         end
         CMD_SEEK: begin
            elapsed_t = seek;
            return;
         end
         CMD_TICK: ;
         default: return;
      endcase
      if (play_state != RS_PLAYING) return;
      if (delay_left_t > 0) begin
         if (d < delay_left_t) begin
            delay_left_t -= d;
            return;
         end
         d -= delay_left_t;
         delay_left_t = 0;
      end
      elapsed_t += d;
      if (elapsed_t > 131071) elapsed_t = 131071;
      dur = (dur_reg == 0) ? 1 : dur_reg;
      if (elapsed_t >= dur) begin
         p = 32768;
         if (loops_left_t != 0) begin
            if (loops_left_t < 128) loops_left_t--;
            elapsed_t = 0;
            if (loops_left_t == 0) begin
               play_state = RS_FINISHED;
               fin = 1'b1;
            end
         end else begin
            play_state = RS_FINISHED;
            fin = 1'b1;
         end
      end else begin
         p = eased((elapsed_t << 15) / dur, mode_reg);
      end
      f.value = blend(p);
      f.progress = p[15:0];
      f.finished = fin;
      frames_due.push_back(f);
   endfunction

   // Valid stays high after the item is taken; the next call or drain drops it.
   task automatic send_cmd(logic [2:0] cmd, logic [15:0] delta, logic [15:0] seek);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_delta <= delta;
      req_seek_position <= seek;
      @(posedge clock iff !req_stall);
      animate(cmd, delta, seek);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock iff csr_ready);
      case (idx)
         CSR_DURATION: dur_reg = data;
         CSR_DELAY: delay_reg = data;
         CSR_LOOP_COUNT: loops_reg = data[7:0];
         CSR_EASING: mode_reg = data[3:0];
         CSR_START: start_reg = data;
         CSR_END: end_reg = data;
         default: ;
      endcase
   endtask

   task automatic setup(logic [15:0] dur, logic [15:0] dly, logic [7:0] loops,
                        logic [3:0] mode, logic [15:0] s, logic [15:0] e);
      drain();
      write_reg(CSR_DURATION, dur);
      write_reg(CSR_DELAY, dly);
      write_reg(CSR_LOOP_COUNT, {8'h00, loops});
      write_reg(CSR_EASING, {12'h000, mode});
      write_reg(CSR_START, s);
      write_reg(CSR_END, e);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      frame_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (frames_due.size() == 0) begin
               $error("unexpected result item: value %0d progress %0d", rsp_value, rsp_progress);
               errors++;
            end else begin
               want = frames_due.pop_front();
               if (rsp_value !== want.value) begin
                  $error("value: expected %0d, actual %0d", want.value, rsp_value);
                  errors++;
               end
               if (rsp_progress !== want.progress) begin
                  $error("progress: expected %0d, actual %0d", want.progress, rsp_progress);
                  errors++;
               end
               if (rsp_finished !== want.finished) begin
                  $error("finished: expected %0b, actual %0b", want.finished, rsp_finished);
                  errors++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic test_directed();
      setup(16'd100, 16'd0, 8'd0, EASE_LINEAR, 16'h8000, 16'h7fff);
      send_cmd(CMD_TICK, 16'd5, 16'd0);        // tick while stopped
      send_cmd(CMD_PAUSE, 16'd0, 16'd0);       // pause while stopped
      send_cmd(CMD_RSVD_LO, 16'hffff, 16'hffff);
      send_cmd(CMD_RSVD_HI, 16'd1, 16'd1);
      send_cmd(CMD_PLAY, 16'd0, 16'd0);
      send_cmd(CMD_TICK, 16'd0, 16'd0);
      send_cmd(CMD_TICK, 16'd50, 16'd0);
      send_cmd(CMD_PLAY, 16'd0, 16'd0);        // play while playing
      send_cmd(CMD_PAUSE, 16'd0, 16'd0);
      send_cmd(CMD_TICK, 16'd1, 16'd0);
      send_cmd(CMD_PLAY, 16'd0, 16'd0);
      send_cmd(CMD_SEEK, 16'd0, 16'd99);
      send_cmd(CMD_TICK, 16'd1, 16'd0);        // final end
      send_cmd(CMD_TICK, 16'd1, 16'd0);
      setup(16'd0, 16'd65535, 8'hff, EASE_RSVD_TOP, 16'h7fff, 16'h8000);
      send_cmd(CMD_PLAY, 16'd0, 16'd0);
      send_cmd(CMD_TICK, 16'd65534, 16'd0);    // inside the delay
      send_cmd(CMD_TICK, 16'hffff, 16'd0);     // leftover carried forward
      send_cmd(CMD_SEEK, 16'd0, 16'hffff);
      send_cmd(CMD_TICK, 16'hffff, 16'd0);
      send_cmd(CMD_STOP, 16'd0, 16'd0);
      setup(16'd65535, 16'd0, 8'd127, EASE_SINE_INOUT, 16'h8000, 16'h7fff);
      send_cmd(CMD_PLAY, 16'd0, 16'd0);
      send_cmd(CMD_SEEK, 16'd0, 16'hfffe);
      send_cmd(CMD_TICK, 16'hffff, 16'd0);     // ends a loop
      send_cmd(CMD_TICK, 16'd32768, 16'd0);
   endtask

   task automatic test_random(int n_phases);
      logic [15:0] dur, a, b;
      int r;
      for (int ph = 0; ph < n_phases; ph++) begin
         case ($urandom_range(3))
            0: dur = $urandom_range(1, 8);
            1: dur = $urandom_range(20, 400);
            2: dur = $urandom;
            default: dur = ($urandom_range(1)) ? 16'hffff : 16'd0;
         endcase
         a = $urandom;
         b = $urandom;
         setup(dur, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20)),
               8'($urandom_range(0, 3) == 0 ? 8'hff : 8'($urandom_range(0, 4))),
               4'($urandom_range(0, 15)), a, b);
         send_cmd(CMD_PLAY, 16'($urandom), 16'($urandom));
         for (int k = 0; k < 50; k++) begin
            r = $urandom_range(99);
            if (r < 75) begin
               send_cmd(CMD_TICK,
                        ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, dur / 4 + 2)),
                        16'($urandom));
            end else if (r < 82) begin
               send_cmd(CMD_PLAY, 16'($urandom), 16'($urandom));
            end else if (r < 87) begin
               send_cmd(CMD_PAUSE, 16'($urandom), 16'($urandom));
            end else if (r < 90) begin
               send_cmd(CMD_STOP, 16'($urandom), 16'($urandom));
            end else if (r < 97) begin
               send_cmd(CMD_SEEK, 16'($urandom), 16'($urandom_range(0, dur)));
            end else begin
               send_cmd(3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI)), 16'($urandom),
                        16'($urandom));
            end
         end
      end
   endtask

   task automatic test_pause_for_drain();
      setup(16'd10, 16'd0, 8'd0, EASE_CUBIC_OUT, 16'd0, 16'd1000);
      send_cmd(CMD_PLAY, 16'd0, 16'd0);
      send_cmd(CMD_TICK, 16'd3, 16'd0);
      drain();
      send_cmd(CMD_TICK, 16'd3, 16'd0);
   endtask

   initial begin
      make_sine_tab();
      dur_reg = 16'd1000; delay_reg = 0; loops_reg = 0; mode_reg = 0;
      start_reg = 0; end_reg = 0;
      play_state = RS_STOPPED; elapsed_t = 0; delay_left_t = 0; loops_left_t = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_idle_pct = 26; recv_idle_pct = 49;
      test_random(10);
      test_pause_for_drain();
      send_idle_pct = 49; recv_idle_pct = 26;
      test_random(10);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(10);
      drain();
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end
endmodule
